// ===== design/tes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types, codes and constants of the timed event scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int unsigned IMMEDIATE_DEPTH_DEF = 4;
  localparam int unsigned TIMED_DEPTH_DEF     = 16;

  localparam logic [31:0] CLOCK_RESET = 32'h8000_0000 - 32'd20_000_000;
  localparam logic [31:0] TICK_RESET  = 32'd1000;

  typedef enum logic [2:0] {
    FN_TICK    = 3'd0,
    FN_NOW     = 3'd1,
    FN_ABS     = 3'd2,
    FN_OFFSET  = 3'd3,
    FN_RUN     = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IMM   = 2'd0,
    ST_TIMED = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

  // t later than r under wrapping 32-bit time
  function automatic logic later_wrap(input logic [31:0] t, input logic [31:0] r);
    logic [31:0] d;
    d = t - r;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage
`default_nettype wire

// ===== design/timed_event_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_scheduler
// Wrapping microsecond clock, immediate FIFO and time-ordered store of
// activation handles, both held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid/tready    | tuser=func[2:0]; tdata=id[15:0],time[47:16]
//  out_    | out | tvalid/tready    | tuser=dispatched[0],status[2:1];
//          |     | tlast=last       | tdata=handed_id[15:0]
//  cfg_    | in  | we (no wait)     | wdata=tick_interval
//
// One transfer in at a time. Tick, schedule-now into the FIFO, zero offset
// and unknown codes go straight to the response. Timed insert scans for the
// first later entry, shifts the tail down one entry at a time (single RAM
// read port) and writes the new entry; a full store drops the request. Run
// hands out the FIFO handles, then the due store entries. Reset restores
// state, clock, tick interval, counters and pointers; RAM contents are not
// cleared. A stalled out_ channel holds the sequencer at each result hand-over.
// ----------------------------------------------------------------------------
module timed_event_scheduler #(
  parameter int unsigned IMMEDIATE_DEPTH = tes_pkg::IMMEDIATE_DEPTH_DEF,
  parameter int unsigned TIMED_DEPTH     = tes_pkg::TIMED_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // activation_id[15:0], time_value[47:16]
  input  wire logic [2:0]  in_tuser,   // func[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // handed_id[15:0]
  output logic [2:0]       out_tuser,  // dispatched[0], status[2:1]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  import tes_pkg::*;

  // widths
  localparam int unsigned TAW = $clog2(TIMED_DEPTH);
  localparam int unsigned TCW = $clog2(TIMED_DEPTH + 1);
  localparam int unsigned IAW = (IMMEDIATE_DEPTH > 1) ? $clog2(IMMEDIATE_DEPTH) : 1;
  localparam int unsigned ICW = $clog2(IMMEDIATE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_INS, S_SCAN_W, S_SHIFT, S_SHIFT_W,
    S_IMM, S_IMM_W, S_TQ, S_TQ_W, S_FIN
  } state_t;

  state_t         state_r;
  logic [31:0]    tick_r, clock_r, last_run_r;
  logic [ICW-1:0] imm_cnt_r, ii_r;
  logic [TCW-1:0] t_cnt_r, i_r, j_r, pos_r;
  logic [TAW-1:0] head_r;
  logic [31:0]    due_r;
  logic [15:0]    id_r;
  logic [1:0]     status_r;
  logic           pend_v_r;
  logic [15:0]    pend_id_r;

  logic           out_valid_r, out_disp_r, out_last_r;
  logic [15:0]    out_id_r;
  logic [1:0]     out_status_r;

  // RAM ports
  logic           t_we, i_we;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [47:0]    t_wdata, t_rdata;
  logic [IAW-1:0] i_raddr;
  logic [15:0]    i_rdata;

  logic           in_xfer, can_emit, emit;
  logic [31:0]    t_due;
  logic [15:0]    t_id;

  // logical list position -> RAM address (circular buffer from head)
  function automatic logic [TAW-1:0] phys(input logic [TAW-1:0] h, input logic [TCW-1:0] l);
    logic [TCW:0] s;
    s = (TCW+1)'(h) + (TCW+1)'(l);
    if (s >= (TCW+1)'(TIMED_DEPTH)) begin
      s = s - (TCW+1)'(TIMED_DEPTH);
    end
    return s[TAW-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign can_emit   = !out_valid_r || out_tready;
  assign t_due      = t_rdata[47:16];
  assign t_id       = t_rdata[15:0];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = {out_status_r, out_disp_r};
  assign out_tlast  = out_last_r;

  // a result transfer is loaded into the output register this cycle
  always_comb begin
    case (state_r) inside
      S_RESP, S_FIN: emit = can_emit;
      S_IMM_W:       emit = pend_v_r && can_emit;
      S_TQ_W:        emit = pend_v_r && can_emit && !later_wrap(t_due, last_run_r);
      default:       emit = 1'b0;
    endcase
  end

  // FIFO write happens straight off the input transfer
  assign i_we    = in_xfer && (func_t'(in_tuser) == FN_NOW) &&
                   (imm_cnt_r < ICW'(IMMEDIATE_DEPTH));
  assign i_raddr = ii_r[IAW-1:0];

  always_comb begin
    t_we    = 1'b0;
    t_waddr = phys(head_r, j_r);
    t_wdata = t_rdata;
    t_raddr = head_r;
    case (state_r)
      S_SCAN_W: t_raddr = phys(head_r, i_r + 1'b1);
      S_SHIFT: begin
        t_raddr = phys(head_r, j_r - 1'b1);
        if (j_r == pos_r) begin
          t_we    = 1'b1;
          t_wdata = {due_r, id_r};
        end
      end
      S_SHIFT_W: t_we = 1'b1;
      default: t_raddr = head_r;
    endcase
  end

  tes_ram #(.W(16), .D(IMMEDIATE_DEPTH), .AW(IAW)) u_imm (
    .clk(clk), .we(i_we), .waddr(imm_cnt_r[IAW-1:0]), .wdata(in_tdata[15:0]),
    .raddr(i_raddr), .rdata(i_rdata)
  );

  tes_ram #(.W(48), .D(TIMED_DEPTH), .AW(TAW)) u_timed (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= TICK_RESET;
      clock_r     <= CLOCK_RESET;
      last_run_r  <= 32'd0;
      imm_cnt_r   <= '0;
      t_cnt_r     <= '0;
      head_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tick_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            id_r <= in_tdata[15:0];
            case (in_tuser)
              FN_TICK: begin
                clock_r  <= clock_r + tick_r;
                status_r <= ST_IMM;
                state_r  <= S_RESP;
              end
              FN_NOW: begin
                if (imm_cnt_r < ICW'(IMMEDIATE_DEPTH)) begin
                  imm_cnt_r <= imm_cnt_r + 1'b1;
                  status_r  <= ST_IMM;
                  state_r   <= S_RESP;
                end else begin
                  due_r   <= last_run_r;
                  state_r <= S_INS;
                end
              end
              FN_ABS: begin
                due_r   <= in_tdata[47:16];
                state_r <= S_INS;
              end
              FN_OFFSET: begin
                if (in_tdata[47:16] == 32'd0) begin
                  status_r <= ST_ZERO;
                  state_r  <= S_RESP;
                end else begin
                  due_r   <= last_run_r + in_tdata[47:16];
                  state_r <= S_INS;
                end
              end
              FN_RUN: begin
                last_run_r <= clock_r;
                ii_r       <= '0;
                pend_v_r   <= 1'b0;
                state_r    <= S_IMM;
              end
              default: begin
                status_r <= ST_IMM;
                state_r  <= S_RESP;
              end
            endcase
          end
        end

        S_RESP: begin
          if (can_emit) begin
            out_disp_r   <= 1'b0;
            out_id_r     <= 16'd0;
            out_status_r <= status_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        // timed insert: forward scan for the first later entry
        S_INS: begin
          if (t_cnt_r == TCW'(TIMED_DEPTH)) begin
            status_r <= ST_FULL;
            state_r  <= S_RESP;
          end else if (t_cnt_r == '0) begin
            pos_r   <= '0;
            j_r     <= '0;
            state_r <= S_SHIFT;
          end else begin
            i_r     <= '0;
            state_r <= S_SCAN_W;
          end
        end

        S_SCAN_W: begin
          if (later_wrap(t_due, due_r)) begin
            pos_r   <= i_r;
            j_r     <= t_cnt_r;
            state_r <= S_SHIFT;
          end else if (i_r + 1'b1 == t_cnt_r) begin
            pos_r   <= t_cnt_r;
            j_r     <= t_cnt_r;
            state_r <= S_SHIFT;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        // shift tail down by one, then drop the new entry in
        S_SHIFT: begin
          if (j_r == pos_r) begin
            t_cnt_r  <= t_cnt_r + 1'b1;
            status_r <= ST_TIMED;
            state_r  <= S_RESP;
          end else begin
            state_r <= S_SHIFT_W;
          end
        end

        S_SHIFT_W: begin
          j_r     <= j_r - 1'b1;
          state_r <= S_SHIFT;
        end

        // run: FIFO first; one handle held back to know which is last
        S_IMM: begin
          if (ii_r < imm_cnt_r) begin
            state_r <= S_IMM_W;
          end else begin
            imm_cnt_r <= '0;
            state_r   <= S_TQ;
          end
        end

        S_IMM_W: begin
          if (!pend_v_r || can_emit) begin
            if (pend_v_r) begin
              out_disp_r   <= 1'b1;
              out_id_r     <= pend_id_r;
              out_status_r <= ST_IMM;
              out_last_r   <= 1'b0;
            end
            pend_v_r  <= 1'b1;
            pend_id_r <= i_rdata;
            ii_r      <= ii_r + 1'b1;
            state_r   <= S_IMM;
          end
        end

        S_TQ: begin
          state_r <= (t_cnt_r == '0) ? S_FIN : S_TQ_W;
        end

        S_TQ_W: begin
          if (later_wrap(t_due, last_run_r)) begin
            state_r <= S_FIN;
          end else if (!pend_v_r || can_emit) begin
            if (pend_v_r) begin
              out_disp_r   <= 1'b1;
              out_id_r     <= pend_id_r;
              out_status_r <= ST_IMM;
              out_last_r   <= 1'b0;
            end
            pend_v_r  <= 1'b1;
            pend_id_r <= t_id;
            head_r    <= phys(head_r, TCW'(1));
            t_cnt_r   <= t_cnt_r - 1'b1;
            state_r   <= S_TQ;
          end
        end

        S_FIN: begin
          if (can_emit) begin
            out_disp_r   <= pend_v_r;
            out_id_r     <= pend_v_r ? pend_id_r : 16'd0;
            out_status_r <= ST_IMM;
            out_last_r   <= 1'b1;
            pend_v_r     <= 1'b0;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tes_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tes_ram #(
  parameter int unsigned W  = 16,
  parameter int unsigned D  = 4,
  parameter int unsigned AW = 2
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
